// ----- hdl/pqf_pkg.sv -----
package pqf_pkg;

    localparam int SLOTS       = 8;
    localparam int MAX_PAYLOAD = 32;

    localparam int HDR_LEN  = 6;
    localparam int TAIL_LEN = 4;

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(MAX_PAYLOAD + 1);
    localparam int POS_W     = $clog2(MAX_PAYLOAD + HDR_LEN + TAIL_LEN + 1);
    localparam int LVL_W     = $clog2(SLOTS + 1);
    localparam int PAY_DEPTH = SLOTS * MAX_PAYLOAD;
    localparam int PAY_AW    = $clog2(PAY_DEPTH);

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_COMMIT = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [6:0]       node;
        logic [CNT_W-1:0] length;
    } slot_info_t;

    function automatic logic [7:0] head_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = 8'hFE;
            2'd1: b = 8'hAA;
            2'd2: b = 8'hFE;
            2'd3: b = 8'h55;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tail_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = 8'hFE;
            2'd1: b = 8'hFF;
            2'd2: b = 8'hFE;
            2'd3: b = 8'hFF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- hdl/pqf_ram.sv -----
module pqf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/packet_queue_framer_top.sv -----
// Channel   Direction  Handshake                Payload
// item      in         start high, busy low     mode, node, data_byte
// result    out        done strobe, one cycle   tx_valid, tx_byte, frame_end, status,
//                                               queue_level
//
// For each item, the accept edge reads the payload and slot memories, and the edge
// while busy is high updates the queue state and registers the result.
// The result shows on the cycle after that, while busy is already low again,
// so a new item can be accepted as soon as the result shows, but not while busy is high.
// Reset clears the slot flags, pointers and counters; the memories are not cleared.
// The receiver cannot stall, so done is never held.
module packet_queue_framer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] mode,
    input  logic [6:0] node,
    input  logic [7:0] data_byte,
    output logic       done,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       frame_end,
    output logic [1:0] status,
    output logic [3:0] queue_level
);

    import pqf_pkg::*;

    localparam int INFO_W = $bits(slot_info_t);

    logic              busy_reg, busy_next;
    logic [1:0]        mode_reg;
    logic [6:0]        node_reg;
    logic [7:0]        data_reg;
    logic [SLOTS-1:0]  full_reg, full_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              active_reg, active_next;
    logic [LVL_W-1:0]  level_reg, level_next;

    logic              done_reg;
    logic              txv_reg, txv_next;
    logic [7:0]        txb_reg, txb_next;
    logic              fend_reg, fend_next;
    logic [1:0]        status_reg, status_next;

    logic              accept;
    logic [POS_W-1:0]  pos_eff;
    logic [CNT_W-1:0]  rd_off;
    logic [PAY_AW-1:0] pay_raddr;
    logic [PAY_AW-1:0] pay_waddr;
    logic              pay_we;
    logic [7:0]        pay_rdata;
    logic              info_we;
    slot_info_t        info_wdata;
    slot_info_t        info_rdata;
    logic [POS_W-1:0]  len_pos;
    logic [POS_W-1:0]  tail_idx;
    logic [7:0]        len_byte;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    assign pos_eff = active_reg ? pos_reg : '0;

    always_comb
    begin
        if (pos_eff >= POS_W'(HDR_LEN) && pos_eff < POS_W'(HDR_LEN + MAX_PAYLOAD))
        begin
            rd_off = CNT_W'(pos_eff - POS_W'(HDR_LEN));
        end
        else
        begin
            rd_off = '0;
        end
    end

    assign pay_raddr = PAY_AW'(rslot_reg) * PAY_AW'(MAX_PAYLOAD) + PAY_AW'(rd_off);
    assign pay_waddr = PAY_AW'(wslot_reg) * PAY_AW'(MAX_PAYLOAD) + PAY_AW'(cnt_reg);

    pqf_ram #(
        .WIDTH(8),
        .DEPTH(PAY_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (data_reg),
        .re    (accept),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    assign info_wdata.node   = node_reg;
    assign info_wdata.length = cnt_reg;

    pqf_ram #(
        .WIDTH(INFO_W),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (info_we),
        .waddr (wslot_reg),
        .wdata (info_wdata),
        .re    (accept),
        .raddr (rslot_reg),
        .rdata (info_rdata)
    );

    assign len_pos  = POS_W'(info_rdata.length);
    assign tail_idx = pos_eff - POS_W'(HDR_LEN) - len_pos;
    assign len_byte = 8'(info_rdata.length) + 8'd2;

    always_comb
    begin
        busy_next   = busy_reg;
        full_next   = full_reg;
        wslot_next  = wslot_reg;
        rslot_next  = rslot_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        active_next = active_reg;
        level_next  = level_reg;
        txv_next    = 1'b0;
        txb_next    = 8'h00;
        fend_next   = 1'b0;
        status_next = STATUS_OK;
        pay_we      = 1'b0;
        info_we     = 1'b0;

        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
            case (mode_reg)
                MODE_APPEND:
                begin
                    if (full_reg[wslot_reg])
                    begin
                        status_next = STATUS_FULL;
                    end
                    else if (cnt_reg >= CNT_W'(MAX_PAYLOAD))
                    begin
                        status_next = STATUS_TOO_LONG;
                    end
                    else
                    begin
                        pay_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                MODE_COMMIT:
                begin
                    if (full_reg[wslot_reg])
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        info_we              = 1'b1;
                        full_next[wslot_reg] = 1'b1;
                        cnt_next             = '0;
                        level_next           = level_reg + 1'b1;
                        if (wslot_reg == SLOT_W'(SLOTS - 1))
                        begin
                            wslot_next = '0;
                        end
                        else
                        begin
                            wslot_next = wslot_reg + 1'b1;
                        end
                    end
                end
                MODE_TICK:
                begin
                    if (active_reg || full_reg[rslot_reg])
                    begin
                        txv_next = 1'b1;
                        if (pos_eff < POS_W'(4))
                        begin
                            txb_next = head_byte(pos_eff[1:0]);
                        end
                        else if (pos_eff == POS_W'(4))
                        begin
                            txb_next = len_byte;
                        end
                        else if (pos_eff == POS_W'(5))
                        begin
                            txb_next = {1'b0, info_rdata.node};
                        end
                        else if (pos_eff < POS_W'(HDR_LEN) + len_pos)
                        begin
                            txb_next = pay_rdata;
                        end
                        else
                        begin
                            txb_next = tail_byte(tail_idx[1:0]);
                        end

                        if (pos_eff + 1'b1 >= POS_W'(HDR_LEN + TAIL_LEN) + len_pos)
                        begin
                            fend_next            = 1'b1;
                            full_next[rslot_reg] = 1'b0;
                            level_next           = level_reg - 1'b1;
                            pos_next             = '0;
                            active_next          = 1'b0;
                            if (rslot_reg == SLOT_W'(SLOTS - 1))
                            begin
                                rslot_next = '0;
                            end
                            else
                            begin
                                rslot_next = rslot_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            pos_next    = pos_eff + 1'b1;
                            active_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            full_reg   <= '0;
            wslot_reg  <= '0;
            rslot_reg  <= '0;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            active_reg <= 1'b0;
            level_reg  <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            done_reg   <= busy_reg && !accept;
            full_reg   <= full_next;
            wslot_reg  <= wslot_next;
            rslot_reg  <= rslot_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            active_reg <= active_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            node_reg <= node;
            data_reg <= data_byte;
        end
        if (busy_reg)
        begin
            txv_reg    <= txv_next;
            txb_reg    <= txb_next;
            fend_reg   <= fend_next;
            status_reg <= status_next;
        end
    end

    assign done        = done_reg;
    assign tx_valid    = txv_reg;
    assign tx_byte     = txb_reg;
    assign frame_end   = fend_reg;
    assign status      = status_reg;
    assign queue_level = level_reg[3:0];

endmodule
